[hdl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain implication property, checked on the rising edge, disabled in reset.
`define CSK_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);
// Next-cycle implication property.
`define CSK_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
		else $error(msg);
`endif

[hdl/csk_pkg.sv]
// Package for the cosine top-k search block: beat types, register indexes,
// opcodes, sequencer states and default sizes. Depends on nothing.
`default_nettype none
package csk_pkg;

	// default sizes
	localparam int unsigned SLOTS_DEF   = 256;
	localparam int unsigned MAX_DIM_DEF = 64;
	localparam int unsigned MAX_TOP_DEF = 16;

	// fixed point format
	localparam int unsigned ELEM_BITS  = 16;
	localparam int unsigned SCORE_FRAC = 15;
	localparam logic signed [15:0] SCORE_MAX = 16'sh7fff;

	// configuration port
	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_QLEN      = 2'd2;
	localparam logic signed [15:0] THRESHOLD_RST = 16'sd0;
	localparam logic [4:0] LIMIT_RST = 5'd16;
	localparam logic [6:0] QLEN_RST  = 7'd64;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_SQ_LD,
		ST_SQRT,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_DEN,
		ST_DIV_LD,
		ST_DIV,
		ST_RANK,
		ST_EMIT_RD,
		ST_EMIT,
		ST_NONE
	} state_t;

	typedef enum logic [1:0] {
		PT_NONE,
		PT_NA,
		PT_DOT,
		PT_NB
	} prod_tag_t;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         slot;
		logic [63:0]        entry_key;
		logic [5:0]         element_index;
		logic signed [15:0] element_value;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic               match_found;
		logic [63:0]        match_key;
		logic [7:0]         match_slot;
		logic signed [15:0] match_score;
		logic [3:0]         match_rank;
		logic [4:0]         match_total;
		logic               final_result;
	} out_item_t;

endpackage
`default_nettype wire

[hdl/cosine_top_k_search.sv]
// Cosine top-k search: keyed vector store, one shared multiplier, square root
// and divider steps under a sequencer, and an insertion-sorted best list.
// Depends on csk_pkg.
`default_nettype none
// After reset the block clears its slot length table, one slot a cycle, and
// stalls input meanwhile. A load beat or a query beat without the last mark
// leaves input unstalled. The last query beat starts a search that stalls
// input until its results are handed to the output register: the query norm
// passes ST_ACC, ST_DRAIN, ST_SQ_LD and ST_SQRT, a slot of other length
// ST_SLOT_RD and ST_SLOT_CHK, a slot of matching length those, the norm
// states, ST_DEN, ST_DIV_LD, ST_DIV and ST_RANK (a zero norm skips ST_DEN
// and the divider, a saturated score the divide steps), with one shared
// multiplier (one product per query element, two per slot element), a
// square root giving two bits of the radicand a cycle and a divider giving
// one quotient bit a cycle. Each result passes ST_EMIT_RD (key memory read)
// and ST_EMIT, the not-found result ST_NONE only, both held by output stall.
module cosine_top_k_search #(
	parameter int unsigned SLOTS   = csk_pkg::SLOTS_DEF,
	parameter int unsigned MAX_DIM = csk_pkg::MAX_DIM_DEF,
	parameter int unsigned MAX_TOP = csk_pkg::MAX_TOP_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  csk_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output csk_pkg::out_item_t                 out_data,
	input  logic                               cfg_wr_en,
	input  logic [csk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [csk_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import csk_pkg::*;

	localparam int unsigned SW    = $clog2(SLOTS);
	localparam int unsigned IW    = $clog2(MAX_DIM);
	localparam int unsigned LW    = $clog2(MAX_DIM + 1);
	localparam int unsigned CMPW  = (LW > 7) ? LW : 7;
	localparam int unsigned TW    = $clog2(MAX_TOP + 1);
	localparam int unsigned XW    = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
	localparam int unsigned VDEPTH = SLOTS * MAX_DIM;
	localparam int unsigned VAW   = $clog2(VDEPTH);
	localparam int unsigned AW0   = 2 * ELEM_BITS + IW;
	localparam int unsigned AW    = AW0 + (AW0 % 2);
	localparam int unsigned SQW   = AW / 2;
	localparam int unsigned DW    = AW + 1;
	localparam int unsigned MW    = (SQW + 1 > ELEM_BITS) ? SQW + 1 : ELEM_BITS;
	localparam int unsigned PW    = 2 * MW;
	localparam int unsigned STEPS = (SQW > SCORE_FRAC) ? SQW : SCORE_FRAC;
	localparam int unsigned STW   = $clog2(STEPS + 1);

	// control state
	state_t state_q, state_d;
	logic signed [15:0] thr_q;
	logic [4:0] limit_q;
	logic [6:0] qlen_q;
	logic out_valid_q;
	out_item_t out_q, out_d;
	logic out_load;

	logic [SW-1:0] s_q;
	logic [VAW-1:0] base_q;
	logic [IW-1:0] ecnt_q;
	logic [1:0] phase_q;
	logic mode_q;
	logic [STW-1:0] step_q;
	logic [TW-1:0] cnt_q, cnt_nx, lim_q, lim_start, lim_m1;
	logic [XW-1:0] rank_q;

	// memories and their read registers
	logic signed [ELEM_BITS-1:0] vec_mem [VDEPTH];
	logic [63:0] key_mem [SLOTS];
	logic [LW-1:0] len_mem [SLOTS];
	logic signed [ELEM_BITS-1:0] qry_mem [MAX_DIM];
	logic signed [ELEM_BITS-1:0] q_rd_s1, v_rd_s1;
	logic [LW-1:0] len_rd_s1;
	logic [63:0] key_rd_s1;

	// arithmetic
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p, prod_s2;
	prod_tag_t tag_d, ptag_s2;
	logic [AW-1:0] acc_na_q, acc_nb_q;
	logic signed [DW-1:0] acc_dot_q;
	logic [AW-1:0] sq_n_q, sq_r_q, sq_bit_q, sq_rb, sq_r_nx;
	logic sq_ge;
	logic [SQW-1:0] sqa_q;
	logic neg_q;
	logic [AW:0] rem_q, rem_sh;
	logic [AW-1:0] den_q, dot_mag;
	logic div_ge;
	logic [SCORE_FRAC-1:0] quo_q, quo_nx;
	logic [15:0] quo_ext;
	logic signed [15:0] score_q;

	// best list
	logic [SW-1:0] best_slot_q [MAX_TOP];
	logic signed [15:0] best_score_q [MAX_TOP];
	logic [MAX_TOP-1:0] gt, first;
	logic ins_ok, pass, do_ins;

	// decoded beat
	logic [SW-1:0] slot_map [256];
	logic [IW-1:0] idx_map [64];
	logic [SW-1:0] ld_slot;
	logic [IW-1:0] ld_idx;
	logic [VAW-1:0] ld_vaddr;
	logic acc_in, load_wr, qry_wr, q_start;
	logic ql_ok, len_match, last_elem, last_slot, elem_end, sq_end, div_end;
	logic is_last_rank, zero_norm, sat;
	state_t fin_st;

	// slot and index reduction tables, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_slot_map
		localparam int unsigned SM = g % SLOTS;
		assign slot_map[g] = SW'(SM);
	end
	for (genvar g = 0; g < 64; g++) begin : g_idx_map
		localparam int unsigned IM = g % MAX_DIM;
		assign idx_map[g] = IW'(IM);
	end

	assign acc_in   = in_valid && !in_stall;
	assign load_wr  = acc_in && (in_data.opcode == OP_LOAD);
	assign qry_wr   = acc_in && (in_data.opcode == OP_QUERY);
	assign q_start  = qry_wr && in_data.last_element;
	assign ld_slot  = slot_map[in_data.slot];
	assign ld_idx   = idx_map[in_data.element_index];
	assign ld_vaddr = VAW'(ld_slot) * VAW'(MAX_DIM) + VAW'(ld_idx);

	assign lim_start = (int'(limit_q) > MAX_TOP) ? TW'(MAX_TOP) : TW'(limit_q);
	assign ql_ok     = (qlen_q != 7'd0) && (int'(qlen_q) <= MAX_DIM);
	assign len_match = (len_rd_s1 != '0) && (CMPW'(len_rd_s1) == CMPW'(qlen_q));
	assign last_elem = (CMPW'(ecnt_q) + CMPW'(1)) == CMPW'(qlen_q);
	assign last_slot = (s_q == SW'(SLOTS - 1));
	assign elem_end  = mode_q ? (phase_q == 2'd2) : (phase_q == 2'd1);
	assign sq_end    = (step_q == STW'(SQW - 1));
	assign div_end   = (step_q == STW'(SCORE_FRAC - 1));
	assign zero_norm = (acc_na_q == '0) || (acc_nb_q == '0);
	assign is_last_rank = (TW'(rank_q) + TW'(1)) == cnt_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		tag_d = PT_NONE;
		case (state_q)
			ST_ACC: begin
				if (phase_q == 2'd1) begin
					mul_a = MW'(q_rd_s1);
					mul_b = mode_q ? MW'(v_rd_s1) : MW'(q_rd_s1);
					tag_d = mode_q ? PT_DOT : PT_NA;
				end else if (phase_q == 2'd2) begin
					mul_a = MW'(v_rd_s1);
					mul_b = MW'(v_rd_s1);
					tag_d = PT_NB;
				end
			end
			ST_DEN: begin
				mul_a = MW'(sqa_q);
				mul_b = MW'(sq_r_q[SQW-1:0]);
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// square root step: two radicand bits per cycle
	assign sq_rb   = sq_r_q + sq_bit_q;
	assign sq_ge   = sq_n_q >= sq_rb;
	assign sq_r_nx = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

	// divide step: one quotient bit per cycle
	assign dot_mag = AW'(acc_dot_q[DW-1] ? -acc_dot_q : acc_dot_q);
	assign sat     = dot_mag >= AW'(prod_s2);
	assign rem_sh  = {rem_q[AW-1:0], 1'b0};
	assign div_ge  = rem_sh >= {1'b0, den_q};
	assign quo_nx  = {quo_q[SCORE_FRAC-2:0], div_ge};
	assign quo_ext = {1'b0, quo_nx};

	// best list insertion: entries below the new score move down one place
	assign lim_m1 = lim_q - TW'(1);
	always_comb begin
		for (int i = 0; i < MAX_TOP; i++) begin
			gt[i] = (TW'(i) >= cnt_q) || (score_q > best_score_q[i]);
		end
		first[0] = gt[0];
		for (int i = 1; i < MAX_TOP; i++) begin
			first[i] = gt[i] && !gt[i-1];
		end
	end
	assign ins_ok = gt[lim_m1[XW-1:0]];
	assign pass   = score_q >= thr_q;
	assign do_ins = (state_q == ST_RANK) && pass && ins_ok;
	assign cnt_nx = (do_ins && (cnt_q < lim_q)) ? cnt_q + TW'(1) : cnt_q;

	// sequencer: next state and output load
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		out_d    = '0;
		fin_st   = (cnt_nx == '0) ? ST_NONE : ST_EMIT_RD;
		case (state_q)
			ST_CLEAR: begin
				if (last_slot) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (q_start) begin
					state_d = (lim_start == '0 || !ql_ok) ? ST_NONE : ST_ACC;
				end
			end
			ST_ACC: begin
				if (elem_end && last_elem) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_SQ_LD;
			ST_SQ_LD: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_end) begin
					if (!mode_q) begin
						state_d = ST_SLOT_RD;
					end else begin
						state_d = zero_norm ? ST_RANK : ST_DEN;
					end
				end
			end
			ST_SLOT_RD: state_d = ST_SLOT_CHK;
			ST_SLOT_CHK: begin
				if (len_match) begin
					state_d = ST_ACC;
				end else begin
					state_d = last_slot ? fin_st : ST_SLOT_RD;
				end
			end
			ST_DEN: state_d = ST_DIV_LD;
			ST_DIV_LD: state_d = sat ? ST_RANK : ST_DIV;
			ST_DIV: begin
				if (div_end) begin
					state_d = ST_RANK;
				end
			end
			ST_RANK: state_d = last_slot ? fin_st : ST_SLOT_RD;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load          = 1'b1;
					out_d.match_found = 1'b1;
					out_d.match_key   = key_rd_s1;
					out_d.match_slot  = 8'(best_slot_q[rank_q]);
					out_d.match_score = best_score_q[rank_q];
					out_d.match_rank  = 4'(rank_q);
					out_d.match_total = 5'(cnt_q);
					out_d.final_result = is_last_rank;
					state_d = is_last_rank ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_NONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load           = 1'b1;
					out_d.final_result = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			thr_q       <= THRESHOLD_RST;
			limit_q     <= LIMIT_RST;
			qlen_q      <= QLEN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_q   <= signed'(cfg_data);
					CFG_LIMIT:     limit_q <= cfg_data[4:0];
					CFG_QLEN:      qlen_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q     <= '0;
			base_q  <= '0;
			ecnt_q  <= '0;
			phase_q <= '0;
			mode_q  <= 1'b0;
			step_q  <= '0;
			cnt_q   <= '0;
			lim_q   <= '0;
			rank_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: s_q <= s_q + SW'(1);
				ST_IDLE: begin
					if (q_start) begin
						s_q     <= '0;
						base_q  <= '0;
						ecnt_q  <= '0;
						phase_q <= '0;
						mode_q  <= 1'b0;
						cnt_q   <= '0;
						rank_q  <= '0;
						lim_q   <= lim_start;
					end
				end
				ST_ACC: begin
					if (elem_end) begin
						phase_q <= '0;
						ecnt_q  <= ecnt_q + IW'(1);
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_SQ_LD, ST_DIV_LD: step_q <= '0;
				ST_SQRT, ST_DIV: step_q <= step_q + STW'(1);
				ST_SLOT_CHK: begin
					if (len_match) begin
						ecnt_q  <= '0;
						phase_q <= '0;
						mode_q  <= 1'b1;
					end else if (!last_slot) begin
						s_q    <= s_q + SW'(1);
						base_q <= base_q + VAW'(MAX_DIM);
					end
				end
				ST_RANK: begin
					cnt_q <= cnt_nx;
					if (!last_slot) begin
						s_q    <= s_q + SW'(1);
						base_q <= base_q + VAW'(MAX_DIM);
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						rank_q <= rank_q + XW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// vector store and key store
	always_ff @(posedge clk) begin
		if (load_wr) begin
			vec_mem[ld_vaddr] <= in_data.element_value;
		end
		v_rd_s1 <= vec_mem[base_q + VAW'(ecnt_q)];
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			key_mem[ld_slot] <= in_data.entry_key;
		end
		key_rd_s1 <= key_mem[best_slot_q[rank_q]];
	end

	// slot lengths: cleared by the sweep after reset, set by the last load beat
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			len_mem[s_q] <= '0;
		end else if (load_wr && in_data.last_element) begin
			len_mem[ld_slot] <= LW'(ld_idx) + LW'(1);
		end
		len_rd_s1 <= len_mem[s_q];
	end

	// query buffer
	always_ff @(posedge clk) begin
		if (qry_wr) begin
			qry_mem[ld_idx] <= in_data.element_value;
		end
		q_rd_s1 <= qry_mem[ecnt_q];
	end

	// product register and accumulators
	always_ff @(posedge clk) begin
		prod_s2 <= mul_p;
		ptag_s2 <= tag_d;
		if (q_start) begin
			acc_na_q <= '0;
		end else if (ptag_s2 == PT_NA) begin
			acc_na_q <= acc_na_q + AW'(prod_s2);
		end
		if (state_q == ST_SLOT_CHK) begin
			acc_dot_q <= '0;
			acc_nb_q  <= '0;
		end else begin
			case (ptag_s2)
				PT_DOT:  acc_dot_q <= acc_dot_q + DW'(prod_s2);
				PT_NB:   acc_nb_q  <= acc_nb_q + AW'(prod_s2);
				default: ;
			endcase
		end
	end

	// square root, divider and score
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SQ_LD: begin
				sq_n_q   <= mode_q ? acc_nb_q : acc_na_q;
				sq_r_q   <= '0;
				sq_bit_q <= AW'(1) << (AW - 2);
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sq_n_q <= sq_n_q - sq_rb;
				end
				sq_r_q   <= sq_r_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_end) begin
					if (!mode_q) begin
						sqa_q <= sq_r_nx[SQW-1:0];
					end else if (zero_norm) begin
						score_q <= '0;
					end
				end
			end
			ST_DIV_LD: begin
				neg_q <= acc_dot_q[DW-1];
				rem_q <= {1'b0, dot_mag};
				den_q <= AW'(prod_s2);
				quo_q <= '0;
				if (sat) begin
					score_q <= acc_dot_q[DW-1] ? -SCORE_MAX : SCORE_MAX;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
				quo_q <= quo_nx;
				if (div_end) begin
					score_q <= neg_q ? -signed'(quo_ext) : signed'(quo_ext);
				end
			end
			default: ;
		endcase
	end

	// best list update
	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int i = 0; i < MAX_TOP; i++) begin
				if (first[i]) begin
					best_slot_q[i]  <= s_q;
					best_score_q[i] <= score_q;
				end else if (gt[i]) begin
					best_slot_q[i]  <= best_slot_q[(i > 0) ? i - 1 : 0];
					best_score_q[i] <= best_score_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

[hdl/csk_checker.sv]
// Port-level checks for the cosine top-k search block, bound to its top.
// Depends on csk_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module csk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input csk_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input csk_pkg::out_item_t out_data
);
	import csk_pkg::*;

	// hold a stalled result beat
	`CSK_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat changed")
	// a closing query beat starts a search that stalls input
	`CSK_ASSERT_NEXT(a_query_stall, clk, arst_n, in_valid && !in_stall && in_data.opcode == OP_QUERY && in_data.last_element, in_stall, "search did not stall input")
	// a load beat never stalls the next one
	`CSK_ASSERT_NEXT(a_load_flow, clk, arst_n, in_valid && !in_stall && in_data.opcode == OP_LOAD, !in_stall, "load beat stalled input")
	// a match beat ranks inside its total
	`CSK_ASSERT(a_rank_total, clk, arst_n, out_valid && out_data.match_found |-> out_data.match_rank < out_data.match_total, "rank outside total")
	// a not-found beat closes the query with an empty total
	`CSK_ASSERT(a_not_found, clk, arst_n, out_valid && !out_data.match_found |-> out_data.final_result && out_data.match_total == 5'd0, "bad not-found beat")

endmodule

bind cosine_top_k_search csk_checker u_csk_checker (.*);
`default_nettype wire

[test/tb_cosine_top_k_search.sv]
// Testbench for the cosine top-k search block: table-driven directed beats,
// then random load/query sequences checked against a behavioral predictor.
// Depends on csk_pkg and cosine_top_k_search.
`default_nettype none
module tb_cosine_top_k_search;
	timeunit 1ns;
	timeprecision 1ps;
	import csk_pkg::*;

	localparam int NSLOT = 256;
	localparam int NDIM = 64;
	localparam int NTOP = 16;
	localparam int QUIET_LIMIT = 300000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_wr_en;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	cosine_top_k_search dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block state
	logic signed [15:0] vec_mem [NSLOT][NDIM];
	bit vec_written [NSLOT][NDIM];
	logic [63:0] key_mem [NSLOT];
	int unsigned len_mem [NSLOT];
	logic signed [15:0] qry_mem [NDIM];
	bit qry_written [NDIM];
	logic signed [15:0] thr_reg;
	logic [4:0] limit_reg;
	logic [6:0] qlen_reg;

	out_item_t pending_results [$];
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit no_idle;

	typedef struct {
		in_item_t beat;
		bit typed;
		out_item_t result;
	} stim_row_t;
	stim_row_t stim_table [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int cosine_score(int unsigned s, int unsigned len);
		longint dot;
		longint na;
		longint nb;
		longint a;
		longint b;
		longint unsigned mag;
		longint unsigned den;
		longint unsigned q;
		dot = 0;
		na = 0;
		nb = 0;
		for (int i = 0; i < len; i++) begin
			a = qry_mem[i];
			b = vec_mem[s][i];
			dot += a * b;
			na += a * a;
			nb += b * b;
		end
		if (na == 0 || nb == 0)
			return 0;
		mag = (dot < 0) ? -dot : dot;
		den = floor_sqrt(na) * floor_sqrt(nb);
		q = (mag << 15) / den;
		if (q > 32767)
			q = 32767;
		return (dot < 0) ? -int'(q) : int'(q);
	endfunction

	// work out the results of one accepted beat and queue them
	function automatic void search_predict(in_item_t it, out_item_t typed_res, bit typed);
		int unsigned top_slot [NTOP];
		int top_score [NTOP];
		int unsigned top_n;
		int unsigned lim;
		int unsigned p;
		int unsigned k;
		int sc;
		out_item_t r;
		if (it.opcode == OP_LOAD) begin
			vec_mem[it.slot][it.element_index] = it.element_value;
			vec_written[it.slot][it.element_index] = 1'b1;
			key_mem[it.slot] = it.entry_key;
			if (it.last_element)
				len_mem[it.slot] = it.element_index + 1;
			return;
		end
		qry_mem[it.element_index] = it.element_value;
		qry_written[it.element_index] = 1'b1;
		if (!it.last_element)
			return;
		lim = (limit_reg > NTOP) ? NTOP : limit_reg;
		top_n = 0;
		if (lim != 0) begin
			for (int s = 0; s < NSLOT; s++) begin
				if (len_mem[s] == 0 || len_mem[s] != qlen_reg)
					continue;
				sc = cosine_score(s, len_mem[s]);
				if (sc < int'(thr_reg))
					continue;
				// insert below every score that is not lower
				p = top_n;
				while (p > 0 && sc > top_score[p-1])
					p--;
				if (p >= lim)
					continue;
				k = (top_n < lim) ? top_n : lim - 1;
				for (; k > p; k--) begin
					top_slot[k] = top_slot[k-1];
					top_score[k] = top_score[k-1];
				end
				top_slot[p] = s;
				top_score[p] = sc;
				if (top_n < lim)
					top_n++;
			end
		end
		if (typed) begin
			pending_results.push_back(typed_res);
			return;
		end
		if (top_n == 0) begin
			r = '0;
			r.final_result = 1'b1;
			pending_results.push_back(r);
			return;
		end
		for (int i = 0; i < top_n; i++) begin
			r.match_found = 1'b1;
			r.match_key = key_mem[top_slot[i]];
			r.match_slot = 8'(top_slot[i]);
			r.match_score = 16'(top_score[i]);
			r.match_rank = 4'(i);
			r.match_total = 5'(top_n);
			r.final_result = (i + 1 == top_n);
			pending_results.push_back(r);
		end
	endfunction

	// drive one beat and hold it until accepted
	task automatic send_beat(in_item_t it, out_item_t typed_res, bit typed);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		search_predict(it, typed_res, typed);
	endtask

	task automatic send(in_item_t it);
		send_beat(it, '0, 1'b0);
	endtask

	// drop input valid after the last beat of a stream
	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// drain, let the block settle, then write one register
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
		release_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_THRESHOLD: thr_reg = val;
			CFG_LIMIT: limit_reg = val[4:0];
			CFG_QLEN: qlen_reg = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] thr, logic [15:0] lim, logic [15:0] ql);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_LIMIT, lim);
		write_reg(CFG_QLEN, ql);
	endtask

	function automatic in_item_t beat(logic op, int unsigned s, logic [63:0] key,
			int unsigned idx, logic [15:0] val, logic last);
		in_item_t it;
		it.opcode = op;
		it.slot = 8'(s);
		it.entry_key = key;
		it.element_index = 6'(idx);
		it.element_value = val;
		it.last_element = last;
		return it;
	endfunction

	function automatic logic [15:0] rand_elem();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// load a whole vector into one slot
	task automatic load_vector(int unsigned s, int unsigned len);
		logic [63:0] key;
		key = rand_key();
		for (int i = 0; i < len; i++)
			send(beat(OP_LOAD, s, key, i, rand_elem(), i == len - 1));
	endtask

	task automatic query_vector(int unsigned len);
		for (int i = 0; i < len; i++)
			send(beat(OP_QUERY, $urandom_range(255), rand_key(), i, rand_elem(),
				i == len - 1));
	endtask

	function automatic bit slot_filled(int unsigned s, int unsigned upto);
		for (int i = 0; i <= upto; i++)
			if (!vec_written[s][i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit query_filled();
		if (qlen_reg == 0 || qlen_reg > NDIM)
			return 1'b1;
		for (int i = 0; i < qlen_reg; i++)
			if (!qry_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// mostly well-formed vectors and queries, the rest noise and broken sequences
	task automatic random_phase(int unsigned nbeats);
		int unsigned sent;
		int unsigned len;
		int unsigned s;
		int unsigned idx;
		in_item_t it;
		sent = 0;
		while (sent < nbeats) begin
			len = (qlen_reg >= 1 && qlen_reg <= NDIM) ? qlen_reg : $urandom_range(1, 4);
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					if ($urandom_range(3) == 0 && len <= 8)
						len = $urandom_range(1, 8);
					s = ($urandom_range(1)) ? $urandom_range(255) : $urandom_range(7);
					load_vector(s, len);
					sent += len;
				end
				4, 5, 6: begin
					query_vector(len);
					sent += len;
				end
				default: begin
					it = beat(1'($urandom_range(1)), $urandom_range(255), rand_key(),
						$urandom_range(63), rand_elem(), 1'($urandom_range(1)));
					if (it.opcode == OP_LOAD) begin
						if (!slot_filled(it.slot, it.element_index))
							it.last_element = 1'b0;
						// the written element may complete the vector
						if ($urandom_range(1) && slot_filled(it.slot, it.element_index))
							it.last_element = 1'b1;
						send(it);
					end else begin
						idx = it.element_index;
						qry_written[idx] = 1'b1;
						if (!query_filled())
							it.last_element = 1'b0;
						qry_written[idx] = 1'b0;
						send(it);
					end
					sent++;
				end
			endcase
		end
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", out_data);
			end else begin
				e = pending_results.pop_front();
				if (out_data.match_found !== e.match_found
						|| out_data.match_key !== e.match_key
						|| out_data.match_slot !== e.match_slot
						|| out_data.match_score !== e.match_score
						|| out_data.match_rank !== e.match_rank
						|| out_data.match_total !== e.match_total
						|| out_data.final_result !== e.final_result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", e, out_data);
				end
			end
		end
	end

	// drive output stall at random
	always @(negedge clk)
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 18);

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		out_item_t none_found;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		thr_reg = THRESHOLD_RST;
		limit_reg = LIMIT_RST;
		qlen_reg = QLEN_RST;
		for (int s = 0; s < NSLOT; s++) begin
			len_mem[s] = 0;
			key_mem[s] = '0;
			for (int i = 0; i < NDIM; i++) begin
				vec_mem[s][i] = '0;
				vec_written[s][i] = 1'b0;
			end
		end
		for (int i = 0; i < NDIM; i++) begin
			qry_mem[i] = '0;
			qry_written[i] = 1'b0;
		end
		none_found = '0;
		none_found.final_result = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: two-element vectors, extremes, zero norm, ties, partial load
		set_config(16'h0000, 16'd16, 16'd2);
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 0, 16'h7fff, 0), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 1, 16'h0000, 1), 1, none_found});
		stim_table.push_back('{beat(OP_LOAD, 0, '1, 0, 16'h7fff, 0), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 0, '1, 1, 16'h0000, 1), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 255, 0, 0, 16'h8000, 0), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 255, 0, 1, 16'h0000, 1), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 7, 64'h5a5a, 0, 16'h0000, 0), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 7, 64'h5a5a, 1, 16'h0000, 1), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 9, 64'h1234, 63, 16'h0005, 0), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, '1, 1, 16'h0000, 1), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 3, 64'h33, 0, 16'h7fff, 0), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 3, 64'h33, 1, 16'h7fff, 1), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 4, 64'h44, 0, 16'h7fff, 0), 0, none_found});
		stim_table.push_back('{beat(OP_LOAD, 4, 64'h44, 1, 16'h7fff, 1), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 0, 16'h4000, 0), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 1, 16'h4000, 1), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 0, 16'h8000, 0), 0, none_found});
		stim_table.push_back('{beat(OP_QUERY, 0, 0, 1, 16'h8000, 1), 0, none_found});
		foreach (stim_table[i])
			send_beat(stim_table[i].beat, stim_table[i].result, stim_table[i].typed);

		// zero limit always gives the not-found result
		set_config(16'h8000, 16'd0, 16'd2);
		send_beat(beat(OP_QUERY, 0, 0, 1, 16'h7fff, 1), none_found, 1'b1);
		// limit above the list size, lowest threshold
		set_config(16'h8000, 16'd31, 16'd2);
		send(beat(OP_QUERY, 0, 0, 1, 16'h7fff, 1));

		// random phases across register settings
		set_config(16'h8000, 16'd16, 16'd4);
		random_phase(40);
		set_config(16'h0000, 16'd3, 16'd4);
		random_phase(30);
		set_config(16'd16384, 16'd5, 16'd3);
		random_phase(30);
		no_idle = 1'b1;
		set_config(16'h8000, 16'd16, 16'd1);
		random_phase(30);
		set_config(16'h7fff, 16'd16, 16'd2);
		random_phase(25);
		no_idle = 1'b0;
		set_config(16'($urandom_range(65535)), 16'($urandom_range(1, 20)), 16'd0);
		random_phase(15);
		set_config(16'hff9c, 16'd31, 16'd100);
		random_phase(15);
		set_config(16'h8000, 16'd7, 16'd8);
		random_phase(50);
		// full length: one slot only, the search is slow
		set_config(16'h8000, 16'd16, 16'd64);
		load_vector($urandom_range(255), 64);
		query_vector(64);
		set_config(16'hc000, 16'd2, 16'd3);
		random_phase(30);

		release_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
